FILE: hdl/rwpf_pkg.sv
package rwpf_pkg;

    // history geometry
    localparam int HISTORY_DEPTH = 16;
    localparam int HIST_IW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int HIST_CW = $clog2(HISTORY_DEPTH + 1);

    // field widths
    localparam int MAC_W = 48;
    localparam int DEV_W = 32;
    localparam int SEQ_W = 32;
    localparam int DEC_W = 2;
    localparam int VERDICT_W = 4;
    localparam int RESP_W = 2;
    localparam int ENTRY_W = DEV_W + SEQ_W;

    // configuration port
    localparam int CFG_IW = 2;
    localparam int CFG_DW = 48;

    typedef enum logic [CFG_IW-1:0] {
        CFG_STRICT_MAC_MODE      = 2'd0,
        CFG_CONFIGURED_MAC       = 2'd1,
        CFG_CONFIGURED_DEVICE_ID = 2'd2
    } cfg_reg_t;

    // decrypt status codes
    localparam logic [DEC_W-1:0] DEC_OK         = 2'd0;
    localparam logic [DEC_W-1:0] DEC_AUTH_FAIL  = 2'd1;
    localparam logic [DEC_W-1:0] DEC_OTHER_FAIL = 2'd2;
    localparam logic [DEC_W-1:0] DEC_SPARE      = 2'd3;

    typedef enum logic [VERDICT_W-1:0] {
        V_ACCEPT       = 4'd0,
        V_DUPLICATE    = 4'd1,
        V_REPLAY       = 4'd2,
        V_BUSY         = 4'd3,
        V_BAD_HEADER   = 4'd4,
        V_BAD_MAC      = 4'd5,
        V_BAD_ID       = 4'd6,
        V_AUTH_FAIL    = 4'd7,
        V_DECRYPT_FAIL = 4'd8
    } verdict_t;

    typedef enum logic [RESP_W-1:0] {
        R_NONE      = 2'd0,
        R_ACK       = 2'd1,
        R_ACK_DUP   = 2'd2,
        R_NACK_BUSY = 2'd3
    } resp_t;

endpackage

FILE: hdl/rwpf_pkt_if.sv
interface rwpf_pkt_if
    import rwpf_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [MAC_W-1:0] source_mac;
    logic [DEV_W-1:0] sender_id;
    logic [SEQ_W-1:0] sequence_req;
    logic             header_ok;
    logic [DEC_W-1:0] decrypt_status;
    logic             downstream_ready;

    modport source (
        output valid, source_mac, sender_id, sequence_req, header_ok,
               decrypt_status, downstream_ready,
        input  ready
    );

    modport sink (
        input  valid, source_mac, sender_id, sequence_req, header_ok,
               decrypt_status, downstream_ready,
        output ready
    );
endinterface

FILE: hdl/rwpf_res_if.sv
interface rwpf_res_if
    import rwpf_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [VERDICT_W-1:0] verdict;
    logic [RESP_W-1:0]    response_kind;
    logic [SEQ_W-1:0]     highest_sequence;
    logic                 learned_now;

    modport source (
        output valid, verdict, response_kind, highest_sequence, learned_now,
        input  ready
    );

    modport sink (
        input  valid, verdict, response_kind, highest_sequence, learned_now,
        output ready
    );
endinterface

FILE: hdl/rwpf_cfg_if.sv
interface rwpf_cfg_if
    import rwpf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [CFG_DW-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );

    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

FILE: hdl/replay_window_packet_filter_core.sv
// an item that passes the early checks reads the history one entry per cycle through
// the memory port, then through one compare stage and a decision state that waits
// for a free result register; an early-dropped item goes to the decision state
// a new item is taken only in the idle state, after the previous result is registered
// reset: asynchronous active low; clears registers, binding and history valid bits,
// history memory contents are not cleared and are masked by the valid bits
module replay_window_packet_filter_core
    import rwpf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rwpf_pkt_if.sink    pkt,
    rwpf_res_if.source  result,
    rwpf_cfg_if.sink    cfg
);

    logic               ram_we;
    logic [HIST_IW-1:0] ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [HIST_IW-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // filter control and check sequencer
    rwpf_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .pkt       (pkt),
        .result    (result),
        .cfg       (cfg),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    // history of device and sequence pairs
    rwpf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

FILE: hdl/rwpf_ram.sv
module rwpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // single write port, registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/rwpf_engine.sv
module rwpf_engine
    import rwpf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    rwpf_pkt_if.sink            pkt,
    rwpf_res_if.source          result,
    rwpf_cfg_if.sink            cfg,
    output logic                ram_we,
    output logic [HIST_IW-1:0]  ram_waddr,
    output logic [ENTRY_W-1:0]  ram_wdata,
    output logic                ram_re,
    output logic [HIST_IW-1:0]  ram_raddr,
    input  logic [ENTRY_W-1:0]  ram_rdata
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } state_t;

    localparam logic [HIST_CW-1:0] SCAN_END = HIST_CW'(HISTORY_DEPTH);
    localparam logic [HIST_IW-1:0] PTR_LAST = HIST_IW'(HISTORY_DEPTH - 1);

    state_t               state_reg, state_next;
    logic                 strict_reg, strict_next;
    logic [MAC_W-1:0]     cfg_mac_reg, cfg_mac_next;
    logic [DEV_W-1:0]     cfg_dev_reg, cfg_dev_next;
    logic [MAC_W-1:0]     bound_mac_reg, bound_mac_next;
    logic [DEV_W-1:0]     bound_dev_reg, bound_dev_next;
    logic                 hist_valid_reg [HISTORY_DEPTH];
    logic                 hist_valid_next [HISTORY_DEPTH];
    logic [HIST_IW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [HIST_CW-1:0]   rd_cnt_reg, rd_cnt_next;
    logic                 cmp_vld_reg, cmp_vld_next;
    logic [HIST_IW-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [DEV_W-1:0]     dev_reg, dev_next;
    logic [SEQ_W-1:0]     seq_reg, seq_next;
    logic                 dsr_reg, dsr_next;
    logic                 drop_reg, drop_next;
    verdict_t             drop_verdict_reg, drop_verdict_next;
    logic                 learned_reg, learned_next;
    logic [SEQ_W-1:0]     high_reg, high_next;
    logic                 dup_reg, dup_next;
    logic                 res_valid_reg, res_valid_next;
    verdict_t             res_verdict_reg, res_verdict_next;
    resp_t                res_resp_reg, res_resp_next;
    logic [SEQ_W-1:0]     res_high_reg, res_high_next;
    logic                 res_learned_reg, res_learned_next;

    logic                 mac_ok;
    logic                 id_ok;
    logic                 learning;
    verdict_t             early_verdict;
    logic                 early_drop;
    logic [DEV_W-1:0]     ent_dev;
    logic [SEQ_W-1:0]     ent_seq;
    logic                 ent_hit;

    assign pkt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign result.valid            = res_valid_reg;
    assign result.verdict          = res_verdict_reg;
    assign result.response_kind    = res_resp_reg;
    assign result.highest_sequence = res_high_reg;
    assign result.learned_now      = res_learned_reg;

    // sender and id checks against the current binding
    always_comb
    begin
        if (pkt.source_mac == '0)
        begin
            mac_ok = 1'b0;
        end
        else if (strict_reg)
        begin
            mac_ok = (bound_mac_reg != '0) && (pkt.source_mac == bound_mac_reg);
        end
        else
        begin
            mac_ok = (bound_dev_reg == '0) || (pkt.source_mac == bound_mac_reg);
        end

        if (strict_reg || (cfg_dev_reg != '0))
        begin
            id_ok = (pkt.sender_id == cfg_dev_reg);
        end
        else
        begin
            id_ok = (bound_dev_reg == '0) || (pkt.sender_id == bound_dev_reg);
        end

        learning = !strict_reg && (cfg_dev_reg == '0);
    end

    // early drop verdict in check order
    always_comb
    begin
        early_drop    = 1'b1;
        early_verdict = V_ACCEPT;
        if (!pkt.header_ok || (pkt.sequence_req == '0))
        begin
            early_verdict = V_BAD_HEADER;
        end
        else if (!mac_ok)
        begin
            early_verdict = V_BAD_MAC;
        end
        else if (!id_ok)
        begin
            early_verdict = V_BAD_ID;
        end
        else if (pkt.decrypt_status == DEC_AUTH_FAIL)
        begin
            early_verdict = V_AUTH_FAIL;
        end
        else if (pkt.decrypt_status != DEC_OK)
        begin
            early_verdict = V_DECRYPT_FAIL;
        end
        else
        begin
            early_drop = 1'b0;
        end
    end

    // history entry returned by the memory
    assign ent_dev = ram_rdata[ENTRY_W-1:SEQ_W];
    assign ent_seq = ram_rdata[SEQ_W-1:0];
    assign ent_hit = cmp_vld_reg && hist_valid_reg[cmp_idx_reg] && (ent_dev == dev_reg);

    // next-state logic
    always_comb
    begin
        state_next        = state_reg;
        strict_next       = strict_reg;
        cfg_mac_next      = cfg_mac_reg;
        cfg_dev_next      = cfg_dev_reg;
        bound_mac_next    = bound_mac_reg;
        bound_dev_next    = bound_dev_reg;
        hist_valid_next   = hist_valid_reg;
        wr_ptr_next       = wr_ptr_reg;
        rd_cnt_next       = rd_cnt_reg;
        cmp_vld_next      = 1'b0;
        cmp_idx_next      = cmp_idx_reg;
        dev_next          = dev_reg;
        seq_next          = seq_reg;
        dsr_next          = dsr_reg;
        drop_next         = drop_reg;
        drop_verdict_next = drop_verdict_reg;
        learned_next      = learned_reg;
        high_next         = high_reg;
        dup_next          = dup_reg;
        res_valid_next    = res_valid_reg && !result.ready;
        res_verdict_next  = res_verdict_reg;
        res_resp_next     = res_resp_reg;
        res_high_next     = res_high_reg;
        res_learned_next  = res_learned_reg;
        ram_we            = 1'b0;
        ram_waddr         = wr_ptr_reg;
        ram_wdata         = {dev_reg, seq_reg};
        ram_re            = 1'b0;
        ram_raddr         = rd_cnt_reg[HIST_IW-1:0];

        // register writes; mac and device id writes also reload the binding
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_STRICT_MAC_MODE:
                begin
                    strict_next = cfg.data[0];
                end
                CFG_CONFIGURED_MAC:
                begin
                    cfg_mac_next   = cfg.data[MAC_W-1:0];
                    bound_mac_next = cfg.data[MAC_W-1:0];
                end
                CFG_CONFIGURED_DEVICE_ID:
                begin
                    cfg_dev_next   = cfg.data[DEV_W-1:0];
                    bound_dev_next = cfg.data[DEV_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (pkt.valid)
                begin
                    dev_next          = pkt.sender_id;
                    seq_next          = pkt.sequence_req;
                    dsr_next          = pkt.downstream_ready;
                    drop_next         = early_drop;
                    drop_verdict_next = early_verdict;
                    learned_next      = 1'b0;
                    high_next         = '0;
                    dup_next          = 1'b0;
                    rd_cnt_next       = '0;
                    if (early_drop)
                    begin
                        state_next = S_DECIDE;
                    end
                    else
                    begin
                        // first authenticated sender binds in learning mode
                        if (learning && (bound_dev_reg == '0))
                        begin
                            bound_dev_next = pkt.sender_id;
                            bound_mac_next = pkt.source_mac;
                            learned_next   = 1'b1;
                        end
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue one read per cycle
                if (rd_cnt_reg != SCAN_END)
                begin
                    ram_re       = 1'b1;
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_cnt_reg[HIST_IW-1:0];
                    rd_cnt_next  = rd_cnt_reg + 1'b1;
                end
                // compare the entry read in the previous cycle
                if (ent_hit)
                begin
                    if (ent_seq > high_reg)
                    begin
                        high_next = ent_seq;
                    end
                    if (ent_seq == seq_reg)
                    begin
                        dup_next = 1'b1;
                    end
                end
                if ((rd_cnt_reg == SCAN_END) && cmp_vld_reg)
                begin
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                // wait until the result register is free
                if (!res_valid_reg || result.ready)
                begin
                    res_valid_next   = 1'b1;
                    res_learned_next = learned_reg;
                    res_high_next    = high_reg;
                    state_next       = S_IDLE;
                    if (drop_reg)
                    begin
                        res_verdict_next = drop_verdict_reg;
                        res_resp_next    = R_NONE;
                        res_high_next    = '0;
                        res_learned_next = 1'b0;
                    end
                    else if (dup_reg)
                    begin
                        res_verdict_next = V_DUPLICATE;
                        res_resp_next    = R_ACK_DUP;
                    end
                    else if ((high_reg != '0) && (seq_reg < high_reg))
                    begin
                        res_verdict_next = V_REPLAY;
                        res_resp_next    = R_NONE;
                    end
                    else if (!dsr_reg)
                    begin
                        res_verdict_next = V_BUSY;
                        res_resp_next    = R_NACK_BUSY;
                    end
                    else
                    begin
                        // accept and insert at the ring pointer
                        res_verdict_next            = V_ACCEPT;
                        res_resp_next               = R_ACK;
                        ram_we                      = 1'b1;
                        hist_valid_next[wr_ptr_reg] = 1'b1;
                        wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            strict_reg       <= 1'b0;
            cfg_mac_reg      <= '0;
            cfg_dev_reg      <= '0;
            bound_mac_reg    <= '0;
            bound_dev_reg    <= '0;
            for (int i = 0; i < HISTORY_DEPTH; i++)
            begin
                hist_valid_reg[i] <= 1'b0;
            end
            wr_ptr_reg       <= '0;
            rd_cnt_reg       <= '0;
            cmp_vld_reg      <= 1'b0;
            cmp_idx_reg      <= '0;
            dev_reg          <= '0;
            seq_reg          <= '0;
            dsr_reg          <= 1'b0;
            drop_reg         <= 1'b0;
            drop_verdict_reg <= V_ACCEPT;
            learned_reg      <= 1'b0;
            high_reg         <= '0;
            dup_reg          <= 1'b0;
            res_valid_reg    <= 1'b0;
            res_verdict_reg  <= V_ACCEPT;
            res_resp_reg     <= R_NONE;
            res_high_reg     <= '0;
            res_learned_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            strict_reg       <= strict_next;
            cfg_mac_reg      <= cfg_mac_next;
            cfg_dev_reg      <= cfg_dev_next;
            bound_mac_reg    <= bound_mac_next;
            bound_dev_reg    <= bound_dev_next;
            hist_valid_reg   <= hist_valid_next;
            wr_ptr_reg       <= wr_ptr_next;
            rd_cnt_reg       <= rd_cnt_next;
            cmp_vld_reg      <= cmp_vld_next;
            cmp_idx_reg      <= cmp_idx_next;
            dev_reg          <= dev_next;
            seq_reg          <= seq_next;
            dsr_reg          <= dsr_next;
            drop_reg         <= drop_next;
            drop_verdict_reg <= drop_verdict_next;
            learned_reg      <= learned_next;
            high_reg         <= high_next;
            dup_reg          <= dup_next;
            res_valid_reg    <= res_valid_next;
            res_verdict_reg  <= res_verdict_next;
            res_resp_reg     <= res_resp_next;
            res_high_reg     <= res_high_next;
            res_learned_reg  <= res_learned_next;
        end
    end

endmodule

FILE: tb/testbench.sv
module testbench;
    import rwpf_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int DRAIN_CYCLES = HISTORY_DEPTH + 8;
    localparam int LONG_HOLD = 300;
    localparam logic [MAC_W-1:0] ALL_ONES_MAC = '1;
    localparam logic [DEV_W-1:0] ALL_ONES_DEV = '1;

    typedef struct {
        logic [MAC_W-1:0] mac;
        logic [DEV_W-1:0] dev;
        logic [SEQ_W-1:0] seq;
        logic             hdr;
        logic [DEC_W-1:0] dec;
        logic             ds_ready;
    } packet_t;

    typedef struct {
        verdict_t         verdict;
        resp_t            resp;
        logic [SEQ_W-1:0] high;
        logic             learned;
    } verdict_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    rwpf_pkt_if pkt_bus ();
    rwpf_res_if res_bus ();
    rwpf_cfg_if cfg_bus ();

    replay_window_packet_filter_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .pkt    (pkt_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    // filter state as predicted
    logic             m_strict;
    logic [DEV_W-1:0] m_cfg_dev;
    logic [MAC_W-1:0] m_bound_mac;
    logic [DEV_W-1:0] m_bound_dev;
    logic             m_hist_valid [HISTORY_DEPTH];
    logic [DEV_W-1:0] m_hist_dev [HISTORY_DEPTH];
    logic [SEQ_W-1:0] m_hist_seq [HISTORY_DEPTH];
    logic [HIST_IW-1:0] m_wp;

    packet_t      pending_packets [$];
    verdict_rec_t expected_verdicts [$];

    packet_t      seen_pkt;
    verdict_rec_t want;
    logic         pkt_took = 1'b0;
    int           pkt_gap = 0;
    int           res_stall = 0;
    int           hold_left = 0;
    logic         hold_req = 1'b0;
    logic         hold_done = 1'b0;
    logic         pkt_idle_en = 1'b1;
    logic         res_idle_en = 1'b1;
    int           error_count = 0;
    int           packets_in = 0;
    int           results_out = 0;
    int           reg_writes = 0;
    int           cycle_count = 0;
    int           verdict_tally [9];

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // timeout guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("replay_window_packet_filter_core test failed");
            $finish;
        end
    end

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[MAC_W-1:0];
    endfunction

    // predicted verdict of one packet, updates binding and history
    function automatic verdict_rec_t judge_packet(packet_t p);
        verdict_rec_t r;
        logic dup;
        logic mac_pass;
        logic id_pass;
        int i;
        r.verdict = V_ACCEPT;
        r.resp = R_NONE;
        r.high = '0;
        r.learned = 1'b0;
        dup = 1'b0;
        // source mac check
        if (p.mac == '0)
            mac_pass = 1'b0;
        else if (m_strict)
            mac_pass = (m_bound_mac != '0) && (p.mac == m_bound_mac);
        else if (m_bound_dev == '0)
            mac_pass = 1'b1;
        else
            mac_pass = (p.mac == m_bound_mac);
        // device id check
        if (m_strict || m_cfg_dev != '0)
            id_pass = (p.dev == m_cfg_dev);
        else
            id_pass = (m_bound_dev == '0) || (p.dev == m_bound_dev);

        if (!p.hdr || p.seq == '0)
            r.verdict = V_BAD_HEADER;
        else if (!mac_pass)
            r.verdict = V_BAD_MAC;
        else if (!id_pass)
            r.verdict = V_BAD_ID;
        else if (p.dec == DEC_AUTH_FAIL)
            r.verdict = V_AUTH_FAIL;
        else if (p.dec != DEC_OK)
            r.verdict = V_DECRYPT_FAIL;
        else
        begin
            // first authenticated sender binds in learning mode
            if (!m_strict && m_cfg_dev == '0 && m_bound_dev == '0)
            begin
                m_bound_dev = p.dev;
                m_bound_mac = p.mac;
                r.learned = 1'b1;
            end
            // history scan for this device
            for (i = 0; i < HISTORY_DEPTH; i++)
            begin
                if (m_hist_valid[i] && m_hist_dev[i] == p.dev)
                begin
                    if (m_hist_seq[i] > r.high)
                        r.high = m_hist_seq[i];
                    if (m_hist_seq[i] == p.seq)
                        dup = 1'b1;
                end
            end
            if (dup)
            begin
                r.verdict = V_DUPLICATE;
                r.resp = R_ACK_DUP;
            end
            else if (r.high != '0 && p.seq < r.high)
                r.verdict = V_REPLAY;
            else if (!p.ds_ready)
            begin
                r.verdict = V_BUSY;
                r.resp = R_NACK_BUSY;
            end
            else
            begin
                m_hist_valid[m_wp] = 1'b1;
                m_hist_dev[m_wp] = p.dev;
                m_hist_seq[m_wp] = p.seq;
                m_wp = (m_wp == HISTORY_DEPTH - 1) ? '0 : m_wp + 1'b1;
                r.verdict = V_ACCEPT;
                r.resp = R_ACK;
            end
        end
        return r;
    endfunction

    task automatic check_field(string what, logic [31:0] got, logic [31:0] exp_val);
        if (got !== exp_val)
        begin
            $display("%0t: result %0d %s mismatch, expected %0h, actual %0h",
                     $time, results_out, what, exp_val, got);
            error_count++;
        end
    endtask

    // accept packets and check results at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            pkt_took = pkt_bus.valid && pkt_bus.ready;
            if (pkt_took)
            begin
                seen_pkt.mac = pkt_bus.source_mac;
                seen_pkt.dev = pkt_bus.sender_id;
                seen_pkt.seq = pkt_bus.sequence_req;
                seen_pkt.hdr = pkt_bus.header_ok;
                seen_pkt.dec = pkt_bus.decrypt_status;
                seen_pkt.ds_ready = pkt_bus.downstream_ready;
                void'(pending_packets.pop_front());
                want = judge_packet(seen_pkt);
                verdict_tally[want.verdict]++;
                expected_verdicts.push_back(want);
                packets_in++;
            end
            if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
            begin
                if (expected_verdicts.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual verdict %0h resp %0h",
                             $time, res_bus.verdict, res_bus.response_kind);
                    error_count++;
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    check_field("verdict", 32'(res_bus.verdict), 32'(want.verdict));
                    check_field("response_kind", 32'(res_bus.response_kind),
                                32'(want.resp));
                    check_field("highest_sequence", res_bus.highest_sequence, want.high);
                    check_field("learned_now", 32'(res_bus.learned_now),
                                32'(want.learned));
                end
                results_out++;
            end
        end
        else
            pkt_took = 1'b0;
    end

    // packet driver, fed from the pending queue
    always @(negedge clk)
    begin
        if (!rst_n)
            pkt_bus.valid <= 1'b0;
        else
        begin
            if (pkt_took && pkt_idle_en && $urandom_range(0, 3) == 0)
                pkt_gap = $urandom_range(1, 16);
            if (pkt_gap > 0)
            begin
                pkt_gap--;
                pkt_bus.valid <= 1'b0;
            end
            else if (pending_packets.size() != 0)
            begin
                pkt_bus.source_mac <= pending_packets[0].mac;
                pkt_bus.sender_id <= pending_packets[0].dev;
                pkt_bus.sequence_req <= pending_packets[0].seq;
                pkt_bus.header_ok <= pending_packets[0].hdr;
                pkt_bus.decrypt_status <= pending_packets[0].dec;
                pkt_bus.downstream_ready <= pending_packets[0].ds_ready;
                pkt_bus.valid <= 1'b1;
            end
            else
                pkt_bus.valid <= 1'b0;
        end
    end

    // result ready: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else
        begin
            if (hold_req && !hold_done && hold_left == 0)
                hold_left = LONG_HOLD;
            if (hold_left > 0)
            begin
                hold_left--;
                if (hold_left == 0)
                    hold_done = 1'b1;
                res_bus.ready <= 1'b0;
            end
            else if (res_stall > 0)
            begin
                res_stall--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                if (res_idle_en && $urandom_range(0, 5) == 0)
                    res_stall = $urandom_range(1, 16);
            end
        end
    end

    function automatic void offer_packet(logic [MAC_W-1:0] mac, logic [DEV_W-1:0] dev,
                                         logic [SEQ_W-1:0] seq, logic hdr,
                                         logic [DEC_W-1:0] dec, logic ds_ready);
        packet_t p;
        p.mac = mac;
        p.dev = dev;
        p.seq = seq;
        p.hdr = hdr;
        p.dec = dec;
        p.ds_ready = ds_ready;
        pending_packets.push_back(p);
    endfunction

    // wait for the block to go idle
    task automatic settle();
        while (pending_packets.size() != 0 || expected_verdicts.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DW-1:0] val);
        @(negedge clk);
        cfg_bus.index <= idx;
        cfg_bus.data <= val;
        cfg_bus.valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        case (idx)
            CFG_STRICT_MAC_MODE:
                m_strict = val[0];
            CFG_CONFIGURED_MAC:
                m_bound_mac = val[MAC_W-1:0];
            CFG_CONFIGURED_DEVICE_ID:
            begin
                m_cfg_dev = val[DEV_W-1:0];
                m_bound_dev = val[DEV_W-1:0];
            end
            default: ;
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_bus.valid <= 1'b0;
    endtask

    // one register setting followed by random traffic
    task automatic run_phase(logic strict_on, logic [MAC_W-1:0] node_mac,
                             logic [DEV_W-1:0] node_dev, logic [DEV_W-1:0] learn_dev,
                             logic [SEQ_W-1:0] seq_start, int count);
        packet_t p;
        logic [MAC_W-1:0] snd_mac;
        logic [DEV_W-1:0] snd_dev;
        logic [SEQ_W-1:0] seq_top;
        logic [CFG_DW-1:0] junk;
        int pick;
        int k;
        settle();
        junk = rand_mac();
        write_reg(CFG_CONFIGURED_MAC, node_mac);
        write_reg(CFG_CONFIGURED_DEVICE_ID, {junk[CFG_DW-1:DEV_W], node_dev});
        write_reg(CFG_STRICT_MAC_MODE, {junk[CFG_DW-1:1], strict_on});
        seq_top = seq_start;
        if (!strict_on && node_dev == '0)
        begin
            // learning: bind a chosen sender first
            snd_mac = rand_mac() | 48'h1;
            snd_dev = learn_dev;
            offer_packet(snd_mac, snd_dev, seq_top, 1'b1, DEC_OK, 1'b1);
        end
        else
        begin
            snd_mac = node_mac;
            snd_dev = node_dev;
        end
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            p.mac = snd_mac;
            p.dev = snd_dev;
            p.hdr = 1'b1;
            p.dec = DEC_OK;
            p.ds_ready = ($urandom_range(0, 9) != 0);
            // new, duplicate or stale sequence from the sender
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5:
                begin
                    seq_top = seq_top + $urandom_range(1, 3);
                    p.seq = seq_top;
                end
                6, 7: p.seq = seq_top - $urandom_range(0, 2);
                default: p.seq = seq_top - $urandom_range(3, 40);
            endcase
            if (p.seq == '0)
                p.seq = 1;
            if (pick >= 70 && pick < 88)
            begin
                // well-formed packet with one field broken
                case ($urandom_range(0, 4))
                    0: p.hdr = 1'b0;
                    1: p.seq = '0;
                    2: p.mac = ($urandom_range(0, 3) == 0) ? '0 : rand_mac();
                    3: p.dev = $urandom();
                    default: p.dec = DEC_W'($urandom_range(1, 3));
                endcase
            end
            else if (pick >= 88)
            begin
                // noise
                p.mac = ($urandom_range(0, 7) == 0) ? '0 : rand_mac();
                p.dev = $urandom();
                p.seq = ($urandom_range(0, 7) == 0) ? '0 : $urandom();
                p.hdr = 1'($urandom_range(0, 1));
                p.dec = DEC_W'($urandom_range(0, 3));
                p.ds_ready = 1'($urandom_range(0, 1));
            end
            pending_packets.push_back(p);
        end
    endtask

    initial
    begin
        pkt_bus.valid = 1'b0;
        pkt_bus.source_mac = '0;
        pkt_bus.sender_id = '0;
        pkt_bus.sequence_req = '0;
        pkt_bus.header_ok = 1'b0;
        pkt_bus.decrypt_status = DEC_OK;
        pkt_bus.downstream_ready = 1'b0;
        res_bus.ready = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = CFG_STRICT_MAC_MODE;
        cfg_bus.data = '0;
        foreach (verdict_tally[j])
            verdict_tally[j] = 0;
        // reset state
        m_strict = 1'b0;
        m_cfg_dev = '0;
        m_bound_mac = '0;
        m_bound_dev = '0;
        m_wp = '0;
        foreach (m_hist_valid[j])
        begin
            m_hist_valid[j] = 1'b0;
            m_hist_dev[j] = '0;
            m_hist_seq[j] = '0;
        end
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // early drops with learning open
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, ALL_ONES_DEV, 1'b0, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, '0, 1'b1, DEC_OK, 1'b1);
        offer_packet('0, ALL_ONES_DEV, 7, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 7, 1'b1, DEC_AUTH_FAIL, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 7, 1'b1, DEC_OTHER_FAIL, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 7, 1'b1, DEC_SPARE, 1'b1);
        // learning with device zero leaves learning open
        offer_packet(48'h1, '0, 1, 1'b1, DEC_OK, 1'b1);
        // binds, then busy: binding stays
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 100, 1'b1, DEC_OK, 1'b0);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 100, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 100, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 50, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, ALL_ONES_DEV, 1'b1, DEC_OK, 1'b1);
        offer_packet(48'h1, ALL_ONES_DEV, 200, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, 32'h1, 200, 1'b1, DEC_OK, 1'b1);
        offer_packet(ALL_ONES_MAC, ALL_ONES_DEV, 200, 1'b1, DEC_OK, 1'b1);
        // device id write drops the binding; relearn on a duplicate
        settle();
        write_reg(CFG_CONFIGURED_DEVICE_ID, '0);
        offer_packet(48'h5A5A_5A5A_5A5A, ALL_ONES_DEV, 100, 1'b1, DEC_OK, 1'b1);
        // strict mode with zero mac rejects everything
        settle();
        write_reg(CFG_CONFIGURED_MAC, '0);
        write_reg(CFG_STRICT_MAC_MODE, 48'h1);
        offer_packet(ALL_ONES_MAC, '0, 5, 1'b1, DEC_OK, 1'b1);
        offer_packet(48'h1, '0, 5, 1'b1, DEC_OK, 1'b1);
        // strict mode with a preset node
        settle();
        write_reg(CFG_CONFIGURED_MAC, 48'h0123_4567_89AB);
        write_reg(CFG_CONFIGURED_DEVICE_ID, 48'h8000_0001);
        offer_packet(48'h0123_4567_89AB, 32'h8000_0001, 1, 1'b1, DEC_OK, 1'b1);
        offer_packet(48'h0123_4567_89AB, ALL_ONES_DEV, 2, 1'b1, DEC_OK, 1'b1);
        offer_packet(48'h0123_4567_89AB, 32'h8000_0001, 1, 1'b1, DEC_OK, 1'b1);

        // random traffic over several settings
        run_phase(1'b0, rand_mac(), '0, $urandom() | 32'h1, 1000, 185);
        hold_req = 1'b1;
        run_phase(1'b1, ALL_ONES_MAC, ALL_ONES_DEV, '0, 32'hFFFF_FF80, 185);
        run_phase(1'b0, rand_mac(), $urandom() | 32'h1, '0, 5000, 185);
        run_phase(1'b1, 48'h1, '0, '0, 300, 185);
        run_phase(1'b0, '0, '0, '0, 2000, 185);
        settle();
        pkt_idle_en = 1'b0;
        res_idle_en = 1'b0;
        run_phase(1'b0, rand_mac(), '0, $urandom() | 32'h1, 777, 190);
        settle();

        $display("covered %0d packets, %0d results, %0d register writes, one %0d-cycle stall",
                 packets_in, results_out, reg_writes, LONG_HOLD);
        $display("verdicts: accept %0d dup %0d replay %0d busy %0d, early drops %0d",
                 verdict_tally[V_ACCEPT], verdict_tally[V_DUPLICATE],
                 verdict_tally[V_REPLAY], verdict_tally[V_BUSY],
                 verdict_tally[V_BAD_HEADER] + verdict_tally[V_BAD_MAC] +
                 verdict_tally[V_BAD_ID] + verdict_tally[V_AUTH_FAIL] +
                 verdict_tally[V_DECRYPT_FAIL]);
        if (error_count == 0)
            $display("replay_window_packet_filter_core test passed");
        else
            $display("replay_window_packet_filter_core test failed");
        $finish;
    end

endmodule
